### rtl/core/qfs_pkg.sv
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared types and constants of the quoted field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package qfs_pkg;

    // Result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CONTENT = 2'd0;
    localparam t_kind KIND_SEP     = 2'd1;
    localparam t_kind KIND_END     = 2'd2;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DELIM_CHARS  = 3'd0;
    localparam t_cfg_idx CFG_OPEN_QUOTE   = 3'd1;
    localparam t_cfg_idx CFG_CLOSE_QUOTE  = 3'd2;
    localparam t_cfg_idx CFG_MAX_FIELDS   = 3'd3;
    localparam t_cfg_idx CFG_IGNORE_EMPTY = 3'd4;

    localparam int CFG_DATA_W = 64;

    typedef logic [7:0] t_byte;
    typedef logic [7:0] t_count;

    localparam t_count COUNT_MAX = 8'hFF;

endpackage

`default_nettype wire

### rtl/core/qfs_in_if.sv
// ----------------------------------------------------------------------------
// qfs_in_if
// Input byte channel: valid/ready handshake with one string byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfs_in_if;
    logic          valid;
    logic          ready;
    qfs_pkg::t_byte ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

### rtl/core/qfs_out_if.sv
// ----------------------------------------------------------------------------
// qfs_out_if
// Result channel: valid/ready handshake with byte, kind, index and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfs_out_if;
    logic            valid;
    logic            ready;
    qfs_pkg::t_byte  out_byte;
    qfs_pkg::t_kind  kind;
    qfs_pkg::t_count field_index;
    qfs_pkg::t_count field_count;

    modport source (output valid, output out_byte, output kind,
                    output field_index, output field_count, input ready);
    modport sink   (input valid, input out_byte, input kind,
                    input field_index, input field_count, output ready);
endinterface

`default_nettype wire

### rtl/core/qfs_delim_match.sv
// ----------------------------------------------------------------------------
// qfs_delim_match
// Parallel compare of one byte against the delimiter list; the list ends
// at its first zero byte.
// ----------------------------------------------------------------------------
`default_nettype none

module qfs_delim_match #(
    parameter int MAX_DELIMS = 8
) (
    input  wire logic [MAX_DELIMS*8-1:0] i_delims,
    input  wire qfs_pkg::t_byte          i_ch,
    output logic                         o_match
);

    logic [MAX_DELIMS-1:0] live;
    logic [MAX_DELIMS-1:0] hit;

    // Mark entries ahead of the first zero byte and compare each one
    always_comb begin
        for (int k = 0; k < MAX_DELIMS; k++) begin
            if (k == 0) begin
                live[k] = (i_delims[7:0] != 8'd0);
            end else begin
                live[k] = live[k-1] && (i_delims[k*8 +: 8] != 8'd0);
            end
            hit[k] = live[k] && (i_delims[k*8 +: 8] == i_ch);
        end
    end

    assign o_match = |hit;

endmodule

`default_nettype wire

### rtl/core/quoted_field_splitter.sv
// ----------------------------------------------------------------------------
// quoted_field_splitter
// Splits a zero-terminated byte string into fields at configured
// delimiters, honoring quote mode and a field limit.
// ----------------------------------------------------------------------------
// An accepted request's result is registered and valid the next cycle.
// Throughput: 1 byte per cycle while the output takes results; the single
//   result register refills in the cycle it drains, so ready stays high.
// Reset (synchronous, active low): sets string state to a string start and
//   clears output valid; max_fields returns to 255, other config to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_field_splitter #(
    parameter int MAX_DELIMS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    qfs_in_if.sink                         i_in,
    qfs_out_if.source                      o_out,
    input  wire logic                      i_cfg_we,
    input  wire qfs_pkg::t_cfg_idx         i_cfg_idx,
    input  wire logic [qfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DELIM_W = MAX_DELIMS * 8;

    // Configuration registers
    logic [DELIM_W-1:0] r_delim_chars;
    qfs_pkg::t_byte     r_open_quote;
    qfs_pkg::t_byte     r_close_quote;
    qfs_pkg::t_count    r_max_fields;
    logic               r_ignore_empty;

    // String state
    logic               r_in_quote,  n_in_quote;
    qfs_pkg::t_count    r_raw_count, n_raw_count;
    qfs_pkg::t_count    r_kept_count, n_kept_count;
    logic               r_has_content, n_has_content;
    logic               r_at_start,  n_at_start;

    // Result register
    logic               r_out_valid;
    qfs_pkg::t_byte     r_out_byte,  n_out_byte;
    qfs_pkg::t_kind     r_kind,      n_kind;
    qfs_pkg::t_count    r_index,     n_index;
    qfs_pkg::t_count    r_count,     n_count;

    logic               in_accept;
    logic               is_delim;
    logic               limited;
    logic               sep;
    qfs_pkg::t_count    raw_now;

    // Take a new request whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    qfs_delim_match #(
        .MAX_DELIMS (MAX_DELIMS)
    ) u_delim_match (
        .i_delims (r_delim_chars),
        .i_ch     (i_in.ch),
        .o_match  (is_delim)
    );

    // Field count as seen by this byte, after a possible string start
    always_comb begin
        if (r_at_start) begin
            raw_now = (r_max_fields != 8'd0) ? 8'd1 : 8'd0;
        end else begin
            raw_now = r_raw_count;
        end
    end

    assign limited = (raw_now == 8'd0) || (raw_now >= r_max_fields);
    assign sep     = !limited && !r_in_quote && (i_in.ch != r_open_quote) && is_delim;

    // Next state and result for one byte
    always_comb begin
        n_in_quote    = r_in_quote;
        n_raw_count   = raw_now;
        n_kept_count  = r_kept_count;
        n_has_content = r_has_content;
        n_at_start    = 1'b0;
        n_out_byte    = i_in.ch;
        n_kind        = qfs_pkg::KIND_CONTENT;
        n_index       = 8'd0;
        n_count       = 8'd0;

        if (i_in.ch == 8'd0) begin
            // End of string: report the count and restart
            n_out_byte = 8'd0;
            n_kind     = qfs_pkg::KIND_END;
            if (!r_at_start) begin
                n_count = r_ignore_empty ? r_kept_count : r_raw_count;
            end
            n_in_quote    = 1'b0;
            n_raw_count   = 8'd0;
            n_kept_count  = 8'd0;
            n_has_content = 1'b0;
            n_at_start    = 1'b1;
        end else begin
            // Toggle quote mode below the field limit
            if (!limited) begin
                if (!r_in_quote && i_in.ch == r_open_quote) begin
                    n_in_quote = 1'b1;
                end else if (r_in_quote && i_in.ch == r_close_quote) begin
                    n_in_quote = 1'b0;
                end
            end

            if (sep) begin
                // Close the field and start the next one
                n_out_byte = 8'd0;
                n_kind     = qfs_pkg::KIND_SEP;
                if (r_ignore_empty) begin
                    n_index = r_has_content ? r_kept_count - 8'd1 : r_kept_count;
                end else begin
                    n_index = raw_now - 8'd1;
                end
                if (raw_now != qfs_pkg::COUNT_MAX) begin
                    n_raw_count = raw_now + 8'd1;
                end
                n_has_content = 1'b0;
            end else begin
                // Content byte: first one in a field makes it a kept field
                if (raw_now != 8'd0 && !r_has_content) begin
                    n_has_content = 1'b1;
                    if (r_kept_count != qfs_pkg::COUNT_MAX) begin
                        n_kept_count = r_kept_count + 8'd1;
                    end
                end
                if (r_ignore_empty) begin
                    n_index = (n_kept_count != 8'd0) ? n_kept_count - 8'd1 : 8'd0;
                end else begin
                    n_index = (raw_now != 8'd0) ? raw_now - 8'd1 : 8'd0;
                end
            end
        end
    end

    // Hold configuration; write on request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_chars  <= '0;
            r_open_quote   <= 8'd0;
            r_close_quote  <= 8'd0;
            r_max_fields   <= qfs_pkg::COUNT_MAX;
            r_ignore_empty <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qfs_pkg::CFG_DELIM_CHARS:  r_delim_chars  <= i_cfg_data[DELIM_W-1:0];
                qfs_pkg::CFG_OPEN_QUOTE:   r_open_quote   <= i_cfg_data[7:0];
                qfs_pkg::CFG_CLOSE_QUOTE:  r_close_quote  <= i_cfg_data[7:0];
                qfs_pkg::CFG_MAX_FIELDS:   r_max_fields   <= i_cfg_data[7:0];
                qfs_pkg::CFG_IGNORE_EMPTY: r_ignore_empty <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Advance string state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote    <= 1'b0;
            r_raw_count   <= 8'd0;
            r_kept_count  <= 8'd0;
            r_has_content <= 1'b0;
            r_at_start    <= 1'b1;
        end else if (in_accept) begin
            r_in_quote    <= n_in_quote;
            r_raw_count   <= n_raw_count;
            r_kept_count  <= n_kept_count;
            r_has_content <= n_has_content;
            r_at_start    <= n_at_start;
        end
    end

    // Result register valid; drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte <= n_out_byte;
            r_kind     <= n_kind;
            r_index    <= n_index;
            r_count    <= n_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.kind        = r_kind;
    assign o_out.field_index = r_index;
    assign o_out.field_count = r_count;

    // An end of string returns the string state to its start
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.ch == 8'd0) |=>
            (r_at_start && !r_in_quote && r_raw_count == 8'd0 && r_kept_count == 8'd0))
        else $error("string state not cleared after end of string");

    // Kept fields never outnumber started fields
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= r_raw_count)
        else $error("kept field count above raw field count");

    // A field count appears only on an end item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != qfs_pkg::KIND_END) |-> (r_count == 8'd0))
        else $error("field count on a non-end result");

endmodule

`default_nettype wire
